FILE: rtl/core/vdc_pkg.sv
// Shared types, constants and register codes for the 2D cross-correlation block.
package vdc_pkg;

  localparam int MAX_KERNEL_DEF = 5;
  localparam int MAX_COLS_DEF   = 1024;
  localparam int MAX_ROWS_DEF   = 1024;

  localparam int SAMPLE_W   = 16;
  localparam int PROD_W     = 32;
  localparam int SUM_W      = 36;
  localparam int POS_W      = 10;
  localparam int TAP_IDX_W  = 5;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 3;

  localparam int RESET_IMAGE_ROWS  = 32;
  localparam int RESET_IMAGE_COLS  = 32;
  localparam int RESET_KERNEL_ROWS = 3;
  localparam int RESET_KERNEL_COLS = 3;

  localparam logic KIND_COEF   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_ROWS  = 3'd0,
    REG_IMAGE_COLS  = 3'd1,
    REG_KERNEL_ROWS = 3'd2,
    REG_KERNEL_COLS = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                       kind;
    logic [TAP_IDX_W-1:0]       coef_index;
    logic signed [SAMPLE_W-1:0] coef_value;
    logic signed [SAMPLE_W-1:0] sample;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0]        out_row;
    logic [POS_W-1:0]        out_col;
    logic signed [SUM_W-1:0] conv_sum;
    logic                    frame_last;
  } out_t;

  typedef struct packed {
    logic shift;
    logic adv;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/valid_2d_cross_correlation.sv
// Top level of the streaming valid-region 2D cross-correlation block.
// Takes one transaction per clock on the input channel: a coefficient load (kind 0)
// or an image sample in raster order (kind 1), and gives one result per sample whose
// window lies fully inside the plane. Throughput is one input transaction per cycle,
// limited by the single write and read port of the line memory, which holds the
// previous MAX_KERNEL-1 rows as one wide word per column. On the way from an accepted
// sample to its result on the output, the accepting edge starts the line read, then
// come the window shift, tap products in the cell row, row sums, and the final sum
// into the output register. A
// one-entry skid stage behind the output register keeps input flowing while one
// result waits; when both are full the input stalls. Coefficient loads travel the
// same pipeline, so they affect only samples that arrive after them. Configuration
// writes restart the raster position and should be issued while the block is idle;
// the line memory needs no clearing pass.
module valid_2d_cross_correlation #(
  parameter int MAX_KERNEL = vdc_pkg::MAX_KERNEL_DEF,
  parameter int MAX_COLS   = vdc_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS   = vdc_pkg::MAX_ROWS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  vdc_pkg::in_t                       in_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output vdc_pkg::out_t                      out_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [vdc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vdc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int K    = MAX_KERNEL;
  localparam int NT   = K * K;
  localparam int LR   = (K > 1) ? K - 1 : 1;
  localparam int SW   = vdc_pkg::SAMPLE_W;
  localparam int LBW  = SW * LR;
  localparam int CW   = $clog2(MAX_COLS);
  localparam int RW   = $clog2(MAX_ROWS);
  localparam int KW   = $clog2(K + 1);
  localparam int CRW  = $clog2(MAX_ROWS + 1);
  localparam int CCW  = $clog2(MAX_COLS + 1);
  localparam int EW   = ((RW > CW) ? RW : CW) + KW + 2;
  localparam int RSW  = vdc_pkg::SUM_W;
  localparam int RST_ROWS = (MAX_ROWS < vdc_pkg::RESET_IMAGE_ROWS) ?
                            MAX_ROWS : vdc_pkg::RESET_IMAGE_ROWS;
  localparam int RST_COLS = (MAX_COLS < vdc_pkg::RESET_IMAGE_COLS) ?
                            MAX_COLS : vdc_pkg::RESET_IMAGE_COLS;
  localparam int RST_KR   = (K < vdc_pkg::RESET_KERNEL_ROWS) ? K : vdc_pkg::RESET_KERNEL_ROWS;
  localparam int RST_KC   = (K < vdc_pkg::RESET_KERNEL_COLS) ? K : vdc_pkg::RESET_KERNEL_COLS;

  // configuration
  logic [CRW-1:0] image_rows;
  logic [CCW-1:0] image_cols;
  logic [KW-1:0]  kernel_rows;
  logic [KW-1:0]  kernel_cols;
  logic           cfg_wr;
  logic [2:0]     cfg_k3;

  // raster position of the next sample
  logic [RW-1:0] row_count;
  logic [CW-1:0] col_count;

  // pipeline control
  logic adv;
  logic in_acc;
  logic in_sample;
  logic in_emit;
  logic in_last;

  // stage 1: line read done
  logic                 s1_valid;
  logic                 s1_kind;
  logic [vdc_pkg::TAP_IDX_W-1:0] s1_idx;
  logic signed [SW-1:0] s1_coef;
  logic signed [SW-1:0] s1_sample;
  logic [CW-1:0]        s1_col;
  logic                 s1_emit;
  logic                 s1_last;
  logic [RW-1:0]        s1_orow;
  logic [CW-1:0]        s1_ocol;
  logic                 s1_fwd_hit;
  logic [LBW-1:0]       s1_fwd_data;
  logic                 s1_write;

  // stages 2 to 4: result bookkeeping
  logic          s2_emit, s3_emit, s4_emit;
  logic          s2_last, s3_last, s4_last;
  logic [RW-1:0] s2_orow, s3_orow, s4_orow;
  logic [CW-1:0] s2_ocol, s3_ocol, s4_ocol;

  // line memory
  logic [LBW-1:0] ram_rdata;
  logic [LBW-1:0] line_word;
  logic [LBW-1:0] line_next;
  logic signed [SW-1:0] col_vec [K];

  // taps
  logic signed [SW-1:0] raw_tap [NT];
  logic signed [SW-1:0] al_tap  [NT];
  logic signed [SW-1:0] al_tap_next [NT];
  logic [KW-1:0] off_r;
  logic [KW-1:0] off_c;

  // cell row
  vdc_pkg::cell_ctrl_t cctrl;
  logic signed [SW-1:0]               win  [NT];
  logic signed [vdc_pkg::PROD_W-1:0]  prod [NT];
  logic signed [RSW-1:0]              row_sum [K];
  logic signed [RSW-1:0]              total;

  // output register and skid stage
  vdc_pkg::out_t res;
  vdc_pkg::out_t skid;
  logic          skid_valid;
  logic          res_valid;

  // ---------------------------------------------------------------------------
  // Configuration: always ready, clamp values, restart the plane on a write to a defined register.
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_k3    = cfg_data[2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows  <= CRW'(RST_ROWS);
      image_cols  <= CCW'(RST_COLS);
      kernel_rows <= KW'(RST_KR);
      kernel_cols <= KW'(RST_KC);
    end else if (cfg_wr) begin
      case (cfg_index)
        vdc_pkg::REG_IMAGE_ROWS: begin
          if (cfg_data == '0) image_rows <= CRW'(1);
          else if (int'(cfg_data) > MAX_ROWS) image_rows <= CRW'(MAX_ROWS);
          else image_rows <= CRW'(cfg_data);
        end
        vdc_pkg::REG_IMAGE_COLS: begin
          if (cfg_data == '0) image_cols <= CCW'(1);
          else if (int'(cfg_data) > MAX_COLS) image_cols <= CCW'(MAX_COLS);
          else image_cols <= CCW'(cfg_data);
        end
        vdc_pkg::REG_KERNEL_ROWS: begin
          if (cfg_k3 == '0) kernel_rows <= KW'(1);
          else if (int'(cfg_k3) > K) kernel_rows <= KW'(K);
          else kernel_rows <= KW'(cfg_k3);
        end
        vdc_pkg::REG_KERNEL_COLS: begin
          if (cfg_k3 == '0) kernel_cols <= KW'(1);
          else if (int'(cfg_k3) > K) kernel_cols <= KW'(K);
          else kernel_cols <= KW'(cfg_k3);
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input side: the whole pipeline moves together unless the skid stage is full.
  // ---------------------------------------------------------------------------
  assign adv       = !skid_valid;
  assign in_ready  = adv;
  assign in_acc    = in_valid && in_ready;
  assign in_sample = in_acc && (in_item.kind == vdc_pkg::KIND_SAMPLE);

  assign in_emit = ((EW'(row_count) + EW'(1)) >= EW'(kernel_rows)) &&
                   ((EW'(col_count) + EW'(1)) >= EW'(kernel_cols));
  assign in_last = ((EW'(row_count) + EW'(1)) == EW'(image_rows)) &&
                   ((EW'(col_count) + EW'(1)) == EW'(image_cols));

  // Advance the raster position on each sample; wrap at the end of row and plane; restart on a configuration write.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (cfg_wr && (cfg_index <= vdc_pkg::REG_KERNEL_COLS)) begin
      row_count <= '0;
      col_count <= '0;
    end else if (in_sample) begin
      if ((EW'(col_count) + EW'(1)) >= EW'(image_cols)) begin
        col_count <= '0;
        if ((EW'(row_count) + EW'(1)) >= EW'(image_rows)) row_count <= '0;
        else row_count <= row_count + RW'(1);
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line memory read returns; build the window column and write back.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind     <= in_item.kind;
      s1_idx      <= in_item.coef_index;
      s1_coef     <= in_item.coef_value;
      s1_sample   <= in_item.sample;
      s1_col      <= col_count;
      s1_emit     <= in_emit;
      s1_last     <= in_last;
      s1_orow     <= RW'(EW'(row_count) + EW'(1) - EW'(kernel_rows));
      s1_ocol     <= CW'(EW'(col_count) + EW'(1) - EW'(kernel_cols));
      // memory returns old data when the same column is written at the read edge
      s1_fwd_hit  <= s1_write && (s1_col == col_count);
      s1_fwd_data <= line_next;
    end
  end

  assign s1_write  = adv && s1_valid && (s1_kind == vdc_pkg::KIND_SAMPLE);
  assign line_word = s1_fwd_hit ? s1_fwd_data : ram_rdata;

  // slot 0 holds the previous row, slot LR-1 the oldest
  always_comb begin
    for (int i = 0; i < K - 1; i++) begin
      col_vec[i] = line_word[(K-2-i)*SW +: SW];
    end
    col_vec[K-1] = s1_sample;
    line_next = '0;
    line_next[SW-1:0] = s1_sample;
    for (int j = 1; j < K - 1; j++) begin
      line_next[j*SW +: SW] = line_word[(j-1)*SW +: SW];
    end
  end

  vdc_ram #(
    .WIDTH (LBW),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_write),
    .waddr (s1_col),
    .wdata (line_next),
    .re    (in_sample),
    .raddr (col_count),
    .rdata (ram_rdata)
  );

  // Coefficient loads land in the tap store as they leave stage 1.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < NT; t++) raw_tap[t] <= '0;
    end else if (adv && s1_valid && (s1_kind == vdc_pkg::KIND_COEF)) begin
      for (int t = 0; t < NT; t++) begin
        if (int'(s1_idx) == t) raw_tap[t] <= s1_coef;
      end
    end
  end

  // Align the taps to the bottom-right corner of the window; unused cells get zero.
  assign off_r = KW'(K) - kernel_rows;
  assign off_c = KW'(K) - kernel_cols;

  always_comb begin
    for (int i = 0; i < K; i++) begin
      for (int j = 0; j < K; j++) begin
        al_tap_next[i*K+j] = '0;
        for (int a = 0; a < K; a++) begin
          for (int b = 0; b < K; b++) begin
            if ((a + int'(off_r) == i) && (b + int'(off_c) == j)) begin
              al_tap_next[i*K+j] = raw_tap[a*K+b];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < NT; t++) al_tap[t] <= '0;
    end else begin
      for (int t = 0; t < NT; t++) al_tap[t] <= al_tap_next[t];
    end
  end

  // ---------------------------------------------------------------------------
  // Cell row: each row of cells shifts left; the new column enters on the right.
  // Cells outside the kernel in use hold stale samples and drop their product.
  // ---------------------------------------------------------------------------
  assign cctrl.shift = s1_write;
  assign cctrl.adv   = adv;

  for (genvar gi = 0; gi < K; gi++) begin : g_row
    for (genvar gj = 0; gj < K; gj++) begin : g_col
      logic signed [SW-1:0] win_in;
      logic                 cell_en;
      assign cell_en = (gi >= int'(off_r)) && (gj >= int'(off_c));
      if (gj == K - 1) begin : g_edge
        assign win_in = col_vec[gi];
      end else begin : g_inner
        assign win_in = win[gi*K+gj+1];
      end
      vdc_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .ctrl   (cctrl),
        .tap_en (cell_en),
        .win_in (win_in),
        .tap    (al_tap[gi*K+gj]),
        .win    (win[gi*K+gj]),
        .prod   (prod[gi*K+gj])
      );
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 2 to 4: products, row sums, then the final sum into the output.
  // ---------------------------------------------------------------------------
  function automatic logic signed [RSW-1:0] row_sum_acc(input int r);
    logic signed [RSW-1:0] acc;
    acc = '0;
    for (int j = 0; j < K; j++) begin
      acc = acc + RSW'(prod[r*K+j]);
    end
    return acc;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_emit <= 1'b0;
      s3_emit <= 1'b0;
      s4_emit <= 1'b0;
    end else if (adv) begin
      s2_emit <= s1_valid && (s1_kind == vdc_pkg::KIND_SAMPLE) && s1_emit;
      s3_emit <= s2_emit;
      s4_emit <= s3_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_last <= s1_last;
      s2_orow <= s1_orow;
      s2_ocol <= s1_ocol;
      s3_last <= s2_last;
      s3_orow <= s2_orow;
      s3_ocol <= s2_ocol;
      s4_last <= s3_last;
      s4_orow <= s3_orow;
      s4_ocol <= s3_ocol;
      for (int i = 0; i < K; i++) begin
        row_sum[i] <= row_sum_acc(i);
      end
    end
  end

  always_comb begin
    total = '0;
    for (int i = 0; i < K; i++) begin
      total = total + row_sum[i];
    end
  end

  always_comb begin
    res.out_row    = vdc_pkg::POS_W'(s4_orow);
    res.out_col    = vdc_pkg::POS_W'(s4_ocol);
    res.conv_sum   = total;
    res.frame_last = s4_last;
  end

  assign res_valid = adv && s4_emit;

  // Output register with a one-entry skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!res_valid) begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      out_valid <= res_valid;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (skid_valid) out_item <= skid;
      else if (res_valid) out_item <= res;
    end else if (!out_valid) begin
      if (res_valid) out_item <= res;
    end else if (res_valid) begin
      skid <= res;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a result while the output register is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && skid_valid) |=> (out_valid && !skid_valid))
    else $error("skid stage did not move into the output register");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !skid_valid && !s1_valid))
    else $error("pipeline not empty after reset");

  a_col_advance: assert property (@(posedge clk) disable iff (rst)
    (in_sample && !cfg_wr && ((EW'(col_count) + EW'(1)) < EW'(image_cols)))
      |=> (col_count == $past(col_count) + CW'(1)))
    else $error("column position did not advance on a sample");

endmodule

FILE: rtl/core/vdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vdc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/vdc_cell.sv
// One window cell: holds a sample, shifts it from its neighbor, registers its product.
module vdc_cell (
  input  logic                                    clk,
  input  logic                                    rst,
  input  vdc_pkg::cell_ctrl_t                     ctrl,
  input  logic                                    tap_en,
  input  logic signed [vdc_pkg::SAMPLE_W-1:0]     win_in,
  input  logic signed [vdc_pkg::SAMPLE_W-1:0]     tap,
  output logic signed [vdc_pkg::SAMPLE_W-1:0]     win,
  output logic signed [vdc_pkg::PROD_W-1:0]       prod
);

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (ctrl.shift) begin
      win <= win_in;
    end
  end

  // advance the product together with the pipeline; cells outside the kernel give zero
  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      if (tap_en) begin
        prod <= win * tap;
      end else begin
        prod <= '0;
      end
    end
  end

endmodule
